### src/csp_pkg.sv
// Shared constants and types for the cylinder support point pipeline.
// No dependencies; imported by cylinder_support_point and its testbench.
package csp_pkg;

	localparam int FRAC_BITS = 16;
	localparam logic [63:0] ZERO_TOL_SQ = 64'd4;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 31;
	localparam int FRONT_STAGES = 6;
	localparam int PIPE_DEPTH = FRONT_STAGES + SQRT_STEPS + DIV_STEPS + 1;
	localparam logic [17:0] AXIS_ONE = 18'(1 << FRAC_BITS);
	localparam logic [30:0] LEN_ONE = 31'(1 << FRAC_BITS);

	typedef enum logic [3:0] {
		REG_CENTER_X    = 4'd0,
		REG_CENTER_Y    = 4'd1,
		REG_CENTER_Z    = 4'd2,
		REG_AXIS_X      = 4'd3,
		REG_AXIS_Y      = 4'd4,
		REG_AXIS_Z      = 4'd5,
		REG_HALF_LENGTH = 4'd6,
		REG_RADIUS      = 4'd7
	} cfg_reg_t;

	// Payload that rides along through the square root and divide stages.
	typedef struct packed {
		logic [2:0][62:0] num;  // radius * |w|
		logic [2:0]       wneg; // sign of w
		logic [2:0][32:0] ax;   // signed axial offset
		logic             flat; // perpendicular part below tolerance
	} tail_t;

endpackage

### src/cylinder_support_point.sv
// Cylinder support mapping for GJK queries, fully pipelined top level.
// Depends on csp_pkg for constants, register codes and the carried payload type.
//
//  channel  | direction | fields
//  s_axis   | in        | tdata: dir_x, dir_y, dir_z
//  m_axis   | out       | tdata: point_x, point_y, point_z; tuser: on_axis
//  cfg      | in        | index, data: one register write per beat
//
// One direction beat is accepted every clock cycle unless a result waits untaken on m_axis.
// The pipeline holds the 32 one-bit square root steps and the 31 one-bit divide steps.
// The whole pipeline advances together, so a stall on m_axis holds every stage.
// The asynchronous reset clears valid bits and restores the register defaults.
module cylinder_support_point (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // dir_x, dir_y, dir_z from bit 0 up
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // point_x, point_y, point_z from bit 0 up
	output logic        m_axis_tuser,  // on_axis
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import csp_pkg::*;

	// Configuration registers.
	logic signed [31:0] center_q [3];
	logic signed [17:0] axis_q [3];
	logic [30:0]        half_q;
	logic [30:0]        radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
			axis_q[0] <= '0;
			axis_q[1] <= '0;
			axis_q[2] <= AXIS_ONE;
			half_q <= LEN_ONE;
			radius_q <= LEN_ONE;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER_X:    center_q[0] <= cfg_data;
				REG_CENTER_Y:    center_q[1] <= cfg_data;
				REG_CENTER_Z:    center_q[2] <= cfg_data;
				REG_AXIS_X:      axis_q[0] <= cfg_data[17:0];
				REG_AXIS_Y:      axis_q[1] <= cfg_data[17:0];
				REG_AXIS_Z:      axis_q[2] <= cfg_data[17:0];
				REG_HALF_LENGTH: half_q <= cfg_data[30:0];
				REG_RADIUS:      radius_q <= cfg_data[30:0];
				default: ; // writes beyond the register list are dropped
			endcase
		end
	end

	// Magnitude and sign of each axis component, used by several stages.
	logic [17:0] amag [3];
	logic        aneg [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			aneg[i] = axis_q[i][17];
			amag[i] = aneg[i] ? 18'(-axis_q[i]) : 18'(axis_q[i]);
		end
	end

	// The pipeline moves as one when the output register is empty or being drained.
	logic                  en;
	logic [PIPE_DEPTH-1:0] vld_q;

	assign en = !vld_q[PIPE_DEPTH-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_q[PIPE_DEPTH-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_DEPTH-2:0], s_axis_tvalid};
		end
	end

	// Stage 1: the three axis-direction products.
	logic signed [31:0] d_s1 [3];
	logic signed [49:0] p_s1 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				d_s1[i] <= s_axis_tdata[32*i +: 32];
				p_s1[i] <= axis_q[i] * $signed(s_axis_tdata[32*i +: 32]);
			end
		end
	end

	// Stage 2: the projection, truncated toward zero, and the cap selection.
	// A projection of exactly zero picks the lower cap.
	logic signed [51:0] uv2;
	logic [51:0]        uv2_mag;
	assign uv2 = 52'(p_s1[0]) + 52'(p_s1[1]) + 52'(p_s1[2]);
	assign uv2_mag = uv2[51] ? 52'(-uv2) : 52'(uv2);

	logic signed [31:0] d_s2 [3];
	logic [35:0]        uvm_s2;
	logic               uvneg_s2;
	logic               sgnneg_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2 <= d_s1;
			uvm_s2 <= 36'(uv2_mag >> FRAC_BITS);
			uvneg_s2 <= uv2[51];
			sgnneg_s2 <= (uv2 <= 52'sd0);
		end
	end

	// Stage 3: projection times axis, kept as a magnitude and a sign.
	logic signed [31:0] d_s3 [3];
	logic [53:0]        pm_s3 [3];
	logic               pneg_s3 [3];
	logic               sgnneg_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			d_s3 <= d_s2;
			sgnneg_s3 <= sgnneg_s2;
			for (int i = 0; i < 3; i++) begin
				pm_s3[i] <= uvm_s2 * amag[i];
				pneg_s3[i] <= uvneg_s2 ^ aneg[i];
			end
		end
	end

	// Stage 4: the perpendicular remainder, saturated to 32 bits.
	logic signed [39:0] wdiff [3];
	always_comb begin
		logic [37:0] t;
		for (int i = 0; i < 3; i++) begin
			t = 38'(pm_s3[i] >> FRAC_BITS);
			wdiff[i] = pneg_s3[i] ? 40'(d_s3[i]) + 40'(t) : 40'(d_s3[i]) - 40'(t);
		end
	end

	logic signed [31:0] w_s4 [3];
	logic               sgnneg_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			sgnneg_s4 <= sgnneg_s3;
			for (int i = 0; i < 3; i++) begin
				if (wdiff[i] > 40'sh007FFFFFFF)
					w_s4[i] <= 32'sh7FFFFFFF;
				else if (wdiff[i] < -40'sh0080000000)
					w_s4[i] <= 32'sh80000000;
				else
					w_s4[i] <= wdiff[i][31:0];
			end
		end
	end

	// Stage 5: squares, radius products and axial products.
	logic [31:0] wmag [3];
	always_comb begin
		for (int i = 0; i < 3; i++)
			wmag[i] = w_s4[i][31] ? 32'(-w_s4[i]) : 32'(w_s4[i]);
	end

	logic [63:0] sq_s5 [3];
	logic [62:0] num_s5 [3];
	logic [48:0] axm_s5 [3];
	logic [2:0]  wneg_s5;
	logic        sgnneg_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			sgnneg_s5 <= sgnneg_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= wmag[i] * wmag[i];
				num_s5[i] <= radius_q * wmag[i];
				axm_s5[i] <= half_q * amag[i];
				wneg_s5[i] <= w_s4[i][31];
			end
		end
	end

	// Stage 6: squared length, tolerance test and signed axial offsets.
	// This register also seeds the square root chain (index 0).
	logic [63:0] sq_x_s [SQRT_STEPS+1];
	logic [63:0] sq_r_s [SQRT_STEPS+1];
	tail_t       sq_t_s [SQRT_STEPS+1];

	always_ff @(posedge clk) begin
		logic [63:0] ww;
		logic [31:0] axv;
		if (en) begin
			ww = sq_s5[0] + sq_s5[1] + sq_s5[2];
			sq_x_s[0] <= ww;
			sq_r_s[0] <= '0;
			sq_t_s[0].flat <= (ww < ZERO_TOL_SQ);
			sq_t_s[0].wneg <= wneg_s5;
			for (int i = 0; i < 3; i++) begin
				axv = 32'(axm_s5[i] >> FRAC_BITS);
				sq_t_s[0].num[i] <= num_s5[i];
				sq_t_s[0].ax[i] <= (sgnneg_s5 ^ aneg[i]) ? 33'(-{1'b0, axv}) : {1'b0, axv};
			end
		end
	end

	// Integer square root, one result bit per stage, most significant first.
	for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_sqrt
		localparam logic [63:0] BITV = 64'd1 << (2 * (SQRT_STEPS - k));
		always_ff @(posedge clk) begin
			logic [63:0] tr;
			if (en) begin
				tr = sq_r_s[k-1] + BITV;
				if (sq_x_s[k-1] >= tr) begin
					sq_x_s[k] <= sq_x_s[k-1] - tr;
					sq_r_s[k] <= (sq_r_s[k-1] >> 1) + BITV;
				end else begin
					sq_x_s[k] <= sq_x_s[k-1];
					sq_r_s[k] <= sq_r_s[k-1] >> 1;
				end
				sq_t_s[k] <= sq_t_s[k-1];
			end
		end
	end

	// Restoring division of radius*|w| by the norm, three lanes, one quotient bit
	// per stage. The quotient never exceeds the radius, so 31 bits suffice.
	logic [31:0]      nrm_first;
	assign nrm_first = (sq_r_s[SQRT_STEPS][31:0] == 32'd0) ? 32'd1 : sq_r_s[SQRT_STEPS][31:0];

	logic [31:0]      dv_n_s   [1:DIV_STEPS];
	logic [2:0][31:0] dv_rem_s [1:DIV_STEPS];
	logic [2:0][30:0] dv_q_s   [1:DIV_STEPS];
	tail_t            dv_t_s   [1:DIV_STEPS];

	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		localparam int B = DIV_STEPS - k;
		logic [31:0]      n_in;
		logic [2:0][31:0] rem_in;
		logic [2:0][30:0] q_in;
		tail_t            t_in;
		if (k == 1) begin : g_seed
			assign n_in = nrm_first;
			assign t_in = sq_t_s[SQRT_STEPS];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign rem_in[i] = sq_t_s[SQRT_STEPS].num[i][62:31];
			end
			assign q_in = '0;
		end else begin : g_chain
			assign n_in = dv_n_s[k-1];
			assign t_in = dv_t_s[k-1];
			assign rem_in = dv_rem_s[k-1];
			assign q_in = dv_q_s[k-1];
		end
		always_ff @(posedge clk) begin
			logic [32:0] tr;
			if (en) begin
				dv_n_s[k] <= n_in;
				dv_t_s[k] <= t_in;
				for (int i = 0; i < 3; i++) begin
					tr = {rem_in[i], t_in.num[i][B]};
					if (tr >= {1'b0, n_in}) begin
						dv_rem_s[k][i] <= 32'(tr - {1'b0, n_in});
						dv_q_s[k][i] <= {q_in[i][29:0], 1'b1};
					end else begin
						dv_rem_s[k][i] <= tr[31:0];
						dv_q_s[k][i] <= {q_in[i][29:0], 1'b0};
					end
				end
			end
		end
	end

	// Output register: center plus axial offset plus radial offset, saturated.
	tail_t            tl;
	logic [2:0][30:0] qf;
	assign tl = dv_t_s[DIV_STEPS];
	assign qf = dv_q_s[DIV_STEPS];

	logic [95:0] pt;
	always_comb begin
		logic signed [34:0] sum;
		logic signed [34:0] rd;
		for (int i = 0; i < 3; i++) begin
			if (tl.flat)
				rd = '0;
			else if (tl.wneg[i])
				rd = -35'($unsigned(qf[i]));
			else
				rd = 35'($unsigned(qf[i]));
			sum = 35'(center_q[i]) + 35'($signed(tl.ax[i])) + rd;
			if (sum > 35'sh07FFFFFFF)
				pt[32*i +: 32] = 32'h7FFFFFFF;
			else if (sum < -35'sh080000000)
				pt[32*i +: 32] = 32'h80000000;
			else
				pt[32*i +: 32] = sum[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_axis_tdata <= pt;
			m_axis_tuser <= tl.flat;
		end
	end

endmodule

### src/csp_checker.sv
// Port-level checks for cylinder_support_point and the bind that attaches them.
// Depends only on the top level's ports.
module csp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic        m_axis_tuser,
	input logic        cfg_ready
);

	// A waiting result is held with its data until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// With nothing waiting at the output, the input side must be open.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input refused with empty output");

	// A draining output never blocks the input.
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input refused while output drains");

	// Register writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind cylinder_support_point csp_checker u_csp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser),
	.cfg_ready     (cfg_ready)
);

### tb/cylinder_support_point_tb.sv
// Self-checking testbench for the cylinder support point pipeline.
// Depends on csp_pkg and cylinder_support_point; predicts each support point locally.
`timescale 1ns / 1ps

module cylinder_support_point_tb;
	import csp_pkg::*;

	typedef struct {
		logic [31:0] px;
		logic [31:0] py;
		logic [31:0] pz;
		logic        flat;
	} support_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// Shadow of the register file, kept at full register width.
	logic signed [31:0] ctr [3];
	logic signed [17:0] axv [3];
	logic [30:0]        half_len;
	logic [30:0]        rad;

	support_t expected_points[$];
	int  mismatches = 0;
	int  cycles = 0;
	bit  stall_enable = 1'b1;
	localparam int CYCLE_LIMIT = 2000000;

	cylinder_support_point i_dut (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one.
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// Support point of the shadow cylinder for one query direction.
	function automatic support_t support_of(logic [95:0] dir);
		support_t res;
		logic signed [63:0] d [3];
		logic signed [63:0] w [3];
		logic signed [63:0] proj2, proj, ax, rd, p, t;
		logic [63:0] ww, nrm, m;
		bit upper, flat;
		proj2 = 0;
		ww = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = $signed(dir[32*i +: 32]);
			proj2 += 64'(axv[i]) * d[i];
		end
		upper = proj2 > 0;
		m = mag64(proj2) >> FRAC_BITS;
		proj = proj2 < 0 ? -$signed(m) : $signed(m);
		for (int i = 0; i < 3; i++) begin
			m = (mag64(proj) * mag64(64'(axv[i]))) >> FRAC_BITS;
			t = ((proj < 0) != (axv[i] < 0)) ? -$signed(m) : $signed(m);
			w[i] = clamp32(d[i] - t);
			ww += mag64(w[i]) * mag64(w[i]);
		end
		flat = ww < ZERO_TOL_SQ;
		nrm = flat ? 64'd1 : root_floor(ww);
		if (nrm == 0) nrm = 1;
		for (int i = 0; i < 3; i++) begin
			m = (64'(half_len) * mag64(64'(axv[i]))) >> FRAC_BITS;
			ax = ((!upper) != (axv[i] < 0)) ? -$signed(m) : $signed(m);
			rd = 0;
			if (!flat) begin
				m = (64'(rad) * mag64(w[i])) / nrm;
				rd = w[i] < 0 ? -$signed(m) : $signed(m);
			end
			p = clamp32(64'(ctr[i]) + ax + rd);
			case (i)
				0: res.px = p[31:0];
				1: res.py = p[31:0];
				default: res.pz = p[31:0];
			endcase
		end
		res.flat = flat;
		return res;
	endfunction

	// Ready on the result side toggles at random unless held high.
	always @(posedge clk) begin
		if (!stall_enable) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 99) < 70);
	end

	// Compare every accepted result beat with the oldest prediction.
	always @(posedge clk) begin
		support_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat %h", m_axis_tdata);
			end else begin
				e = expected_points.pop_front();
				if (m_axis_tdata !== {e.pz, e.py, e.px} || m_axis_tuser !== e.flat) begin
					mismatches++;
					if (mismatches <= 10)
						$display("point mismatch: exp %h/%h/%h on_axis %b, got %h/%h/%h on_axis %b",
							e.px, e.py, e.pz, e.flat, m_axis_tdata[31:0],
							m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tuser);
				end
			end
		end
	end

	// Send one direction beat; the prediction is queued at acceptance.
	// Valid stays high after the beat so that the next call can follow without a gap;
	// it drops at the start of a gap or when the sender drains.
	task automatic send_dir(logic [31:0] dx, logic [31:0] dy, logic [31:0] dz);
		int g;
		g = gap_len();
		if (g != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {dz, dy, dx};
		do @(posedge clk); while (!s_axis_tready);
		expected_points.push_back(support_of({dz, dy, dx}));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		// Let the pipeline settle past its depth.
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	// Register write; the shadow copy applies the same width masking.
	task automatic write_reg(logic [3:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_CENTER_X: ctr[0] = val;
			REG_CENTER_Y: ctr[1] = val;
			REG_CENTER_Z: ctr[2] = val;
			REG_AXIS_X: axv[0] = val[17:0];
			REG_AXIS_Y: axv[1] = val[17:0];
			REG_AXIS_Z: axv[2] = val[17:0];
			REG_HALF_LENGTH: half_len = val[30:0];
			REG_RADIUS: rad = val[30:0];
			default: ;
		endcase
	endtask

	task automatic set_cylinder(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
			logic [31:0] hl, logic [31:0] r);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
		write_reg(REG_AXIS_X, ax);
		write_reg(REG_AXIS_Y, ay);
		write_reg(REG_AXIS_Z, az);
		write_reg(REG_HALF_LENGTH, hl);
		write_reg(REG_RADIUS, r);
	endtask

	// Directions that land on the extremes and the special cases.
	task automatic test_directed();
		send_dir(0, 0, 0);                         // zero projection picks the lower cap
		send_dir(0, 0, 32'h0001_0000);             // on the axis, upper cap
		send_dir(0, 0, 32'hFFFF_0000);             // on the axis, lower cap
		send_dir(32'h0001_0000, 0, 0);             // pure radial
		send_dir(1, 0, 0);                         // tiny remainder, below tolerance
		send_dir(2, 0, 0);                         // remainder exactly at tolerance
		send_dir(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_dir(32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_dir(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();
		// Large center and radius values drive coordinates into saturation.
		set_cylinder(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_0000, 32'h1_0000, 0, 0,
			32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_dir(32'h0001_0000, 32'hFFFF_0000, 0);
		send_dir(32'hFFFF_0000, 32'h0001_0000, 32'h7FFF_FFFF);
		send_dir(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
		drain();
		// Non-unit axes at the register limits, ignored upper data bits, bad indices.
		set_cylinder(0, 0, 0, 32'hFFFE_0000, 32'h0001_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h8000_0001);
		write_reg(4'd8, 32'hDEAD_BEEF);
		write_reg(4'd15, 32'h1234_5678);
		send_dir(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		send_dir(32'h0002_0000, 32'h0003_0000, 32'hFFFC_0000);
		send_dir(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_dir(0, 0, 0);
		drain();
		set_cylinder(0, 0, 0, 0, 0, 0, 0, 0);      // degenerate cylinder
		send_dir(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		send_dir(0, 0, 1);
		drain();
	endtask

	function automatic logic [31:0] rand_dir_field();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return $urandom_range(0, 8) - 4;                   // near zero
			2: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
			3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
		endcase
	endfunction

	// Random axes and moderate sizes, with the occasional wild setting.
	task automatic random_cylinder();
		int k;
		k = $urandom_range(0, 2);
		write_reg(REG_CENTER_X, k == 0 ? $urandom() : $urandom_range(0, 32'h00FF_FFFF));
		write_reg(REG_CENTER_Y, k == 0 ? $urandom() : $urandom_range(0, 32'h00FF_FFFF));
		write_reg(REG_CENTER_Z, $urandom());
		write_reg(REG_AXIS_X, $urandom());
		write_reg(REG_AXIS_Y, $urandom());
		write_reg(REG_AXIS_Z, k == 1 ? 32'h0001_0000 : $urandom());
		write_reg(REG_HALF_LENGTH, k == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000));
		write_reg(REG_RADIUS, k == 0 ? $urandom() : $urandom_range(0, 32'h0010_0000));
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			if (i % 300 == 0) begin
				drain();
				random_cylinder();
			end
			if (i % 500 == 250) stall_enable = 1'b0;   // run without stalls for a while
			if (i % 500 == 400) stall_enable = 1'b1;
			if ($urandom_range(0, 3) == 0)
				send_dir(rand_dir_field(), rand_dir_field(), rand_dir_field());
			else
				send_dir($urandom(), $urandom(), $urandom());
		end
		stall_enable = 1'b1;
	endtask

	// Back-to-back beats after a full drain, no sender gaps.
	task automatic test_burst();
		drain();
		stall_enable = 1'b0;
		for (int i = 0; i < 40; i++) begin
			s_axis_tvalid <= 1'b1;
			s_axis_tdata <= {$urandom(), $urandom(), $urandom()};
			do @(posedge clk); while (!s_axis_tready);
			expected_points.push_back(support_of(s_axis_tdata));
		end
		s_axis_tvalid <= 1'b0;
		stall_enable = 1'b1;
		drain();
	endtask

	initial begin
		ctr[0] = 0; ctr[1] = 0; ctr[2] = 0;
		axv[0] = 0; axv[1] = 0; axv[2] = AXIS_ONE;
		half_len = LEN_ONE;
		rad = LEN_ONE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(1500);
		test_burst();
		drain();
		if (mismatches == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule
